/* rtl/core/assert_macros.svh */
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every clock, held off during reset
`define ASSERT_IMPL(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

/* rtl/core/isodur_pkg.sv */
// ----------------------------------------------------------------------------
// isodur_pkg
// constants shared by the duration text parser
// ----------------------------------------------------------------------------
package isodur_pkg;
    localparam int MAX_CHARS = 63;
    localparam int AW        = $clog2(MAX_CHARS + 1);
    localparam int LW        = $clog2(MAX_CHARS + 1);

    localparam logic [7:0] CH_P  = 8'h50;
    localparam logic [7:0] CH_LP = 8'h70;

    // fold ascii letter to upper case
    function automatic logic [7:0] up_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7a) r = c - 8'h20;
        return r;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction
endpackage

/* rtl/core/isodur_scan.sv */
// ----------------------------------------------------------------------------
// isodur_scan
// walks the stored text, locates indicators and converts numbers
// ----------------------------------------------------------------------------
module isodur_scan
    import isodur_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [LW-1:0]      eff_len,
    output logic [AW-1:0]      rd_addr,
    input  logic [7:0]         rd_data,
    output logic               done,
    output logic               status,
    output logic [7*32-1:0]    parts
);
    // phases: check leading P, locate t, locate w, then per-unit find + convert
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHKP  = 4'd1;
    localparam logic [3:0] S_FINDT = 4'd2;
    localparam logic [3:0] S_FINDW = 4'd3;
    localparam logic [3:0] S_FIND  = 4'd4;
    localparam logic [3:0] S_NWS   = 4'd5;
    localparam logic [3:0] S_NDIG  = 4'd6;
    localparam logic [3:0] S_NMUL  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    // unit order: Y M D H M S W ; stage index 0..6
    logic [3:0]      st_reg, st_next;
    logic [LW:0]     pos_reg, pos_next;      // address presented this cycle
    logic            wait_reg, wait_next;    // read data not yet valid
    logic [LW:0]     s_reg, s_next, t_reg, t_next, w_reg, w_next, x_reg, x_next;
    logic [2:0]      u_reg, u_next;
    logic            nw_reg, nw_next, neg_reg, neg_next;
    logic            err_reg, err_next;
    logic [31:0]     v_reg, v_next, mul_reg, mul_next;
    logic [7*32-1:0] parts_reg, parts_next;
    logic [LW:0]     len_ext;
    logic [7:0]      cu;
    logic [7:0]      tgt;
    logic            have_t;
    logic            take;

    assign len_ext = {1'b0, eff_len};
    assign rd_addr = pos_reg[AW-1:0];
    assign cu      = up_case(rd_data);
    assign have_t  = t_reg < len_ext;
    assign done    = (st_reg == S_DONE);
    assign status  = err_reg;
    assign parts   = parts_reg;

    always_comb begin
        unique case (u_reg)
            3'd0:    tgt = 8'h59;
            3'd1:    tgt = 8'h4d;
            3'd2:    tgt = 8'h44;
            3'd3:    tgt = 8'h48;
            3'd4:    tgt = 8'h4d;
            3'd5:    tgt = 8'h53;
            default: tgt = 8'h57;
        endcase
    end

    // accept rule for an indicator found at the current position
    always_comb begin
        unique case (u_reg)
            3'd1:    take = !have_t || (pos_reg < t_reg);
            3'd3,
            3'd5:    take = have_t;
            3'd4:    take = have_t && (pos_reg > t_reg);
            default: take = 1'b1;
        endcase
    end

    always_comb begin
        st_next = st_reg; pos_next = pos_reg; wait_next = 1'b0;
        s_next = s_reg; t_next = t_reg; w_next = w_reg; x_next = x_reg;
        u_next = u_reg; nw_next = nw_reg; neg_next = neg_reg;
        err_next = err_reg; v_next = v_reg; mul_next = mul_reg;
        parts_next = parts_reg;
        unique case (st_reg)
            S_IDLE: begin
                if (start) begin
                    parts_next = '0; err_next = 1'b0; nw_next = 1'b0;
                    pos_next = '0; wait_next = 1'b1; st_next = S_CHKP;
                end
            end
            S_CHKP: begin
                if (!wait_reg) begin
                    if (len_ext == '0 || !(rd_data == CH_P || rd_data == CH_LP)) begin
                        err_next = 1'b1; st_next = S_DONE;
                    end else begin
                        t_next = len_ext; pos_next = '0; wait_next = 1'b1;
                        st_next = S_FINDT;
                    end
                end
            end
            S_FINDT: begin
                if (!wait_reg) begin
                    if (pos_reg >= len_ext || cu == 8'h54) begin
                        t_next = pos_reg; pos_next = '0; wait_next = 1'b1;
                        st_next = S_FINDW;
                    end else begin
                        pos_next = pos_reg + 1'b1; wait_next = 1'b1;
                    end
                end
            end
            S_FINDW: begin
                if (!wait_reg) begin
                    if (pos_reg >= len_ext || cu == 8'h57) begin
                        w_next = pos_reg; s_next = '0; u_next = 3'd0;
                        pos_next = '0; wait_next = 1'b1; st_next = S_FIND;
                    end else begin
                        pos_next = pos_reg + 1'b1; wait_next = 1'b1;
                    end
                end
            end
            S_FIND: begin
                if (u_reg == 3'd6) begin
                    if (w_reg < len_ext) begin
                        if (nw_reg) begin
                            err_next = 1'b1; st_next = S_DONE;
                        end else begin
                            x_next = w_reg; pos_next = s_reg + 1'b1;
                            wait_next = 1'b1; st_next = S_NWS;
                        end
                    end else begin
                        st_next = S_FIN;
                    end
                end else if (!wait_reg) begin
                    if (pos_reg >= len_ext || cu == tgt) begin
                        x_next = pos_reg;
                        if (pos_reg < len_ext && take) begin
                            pos_next = s_reg + 1'b1; wait_next = 1'b1; st_next = S_NWS;
                        end else begin
                            // not taken: next unit, after D jump to t if present
                            u_next = u_reg + 1'b1;
                            if (u_reg == 3'd2 && have_t) begin
                                s_next = t_reg; nw_next = 1'b1; pos_next = t_reg;
                            end else begin
                                pos_next = s_reg;
                            end
                            wait_next = 1'b1;
                        end
                    end else begin
                        pos_next = pos_reg + 1'b1; wait_next = 1'b1;
                    end
                end
            end
            S_NWS: begin
                if (!wait_reg) begin
                    v_next = '0; neg_next = 1'b0;
                    if (pos_reg < len_ext && is_ws(rd_data)) begin
                        pos_next = pos_reg + 1'b1; wait_next = 1'b1;
                    end else if (pos_reg < len_ext &&
                                 (rd_data == 8'h2b || rd_data == 8'h2d)) begin
                        neg_next = (rd_data == 8'h2d);
                        pos_next = pos_reg + 1'b1; wait_next = 1'b1; st_next = S_NDIG;
                    end else begin
                        st_next = S_NDIG;
                    end
                end
            end
            S_NDIG: begin
                if (!wait_reg) begin
                    if (pos_reg < len_ext && is_digit(rd_data)) begin
                        mul_next = {v_reg[28:0], 3'b000} + {v_reg[30:0], 1'b0};
                        v_next = {24'd0, rd_data - 8'h30};
                        st_next = S_NMUL;
                    end else begin
                        v_next = neg_reg ? (32'd0 - v_reg) : v_reg;
                        parts_next[32*(u_reg == 3'd6 ? 2 :
                                       u_reg == 3'd0 ? 0 :
                                       u_reg == 3'd1 ? 1 :
                                       u_reg == 3'd2 ? 3 :
                                       u_reg == 3'd3 ? 4 :
                                       u_reg == 3'd4 ? 5 : 6) +: 32] =
                            neg_reg ? (32'd0 - v_reg) : v_reg;
                        s_next = x_reg; nw_next = (u_reg != 3'd6) ? 1'b1 : nw_reg;
                        if (u_reg == 3'd6) begin
                            st_next = S_FIN;
                        end else begin
                            u_next = u_reg + 1'b1;
                            if (u_reg == 3'd2 && have_t) begin
                                s_next = t_reg; pos_next = t_reg;
                            end else begin
                                pos_next = x_reg;
                            end
                            wait_next = 1'b1; st_next = S_FIND;
                        end
                    end
                end
            end
            S_NMUL: begin
                v_next = mul_reg + v_reg;
                pos_next = pos_reg + 1'b1; wait_next = 1'b1; st_next = S_NDIG;
            end
            S_FIN: begin
                if (s_reg + 1'b1 < len_ext) err_next = 1'b1;
                st_next = S_DONE;
            end
            S_DONE:  st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            wait_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            wait_reg <= wait_next;
        end
        pos_reg <= pos_next; s_reg <= s_next; t_reg <= t_next; w_reg <= w_next;
        x_reg <= x_next; u_reg <= u_next; nw_reg <= nw_next; neg_reg <= neg_next;
        err_reg <= err_next; v_reg <= v_next;
        mul_reg <= mul_next; parts_reg <= parts_next;
    end
endmodule

/* rtl/core/iso_duration_text_parser.sv */
// ----------------------------------------------------------------------------
// iso_duration_text_parser
// ISO 8601 duration text parser with text held in a one-write one-read buffer
// ----------------------------------------------------------------------------
// input words carry one text byte each, s_last_char marks the final byte.
// each of the first 63 bytes is written to a 63-entry text buffer; the
// word with s_last_char starts a scan over the buffer which yields one
// result word: status and seven 32-bit parts. ordinary bytes are taken
// back to back. the scan reads the buffer through a registered read
// port, so it waits for the data of each byte it looks at: it searches
// for T, then for W, then for each unit for its indicator and number.
// input ready is low during the scan and while a result waits in the
// output register; a stalled receiver holds the result and the block takes
// no more bytes until it is taken. reset clears the text length and flags;
// buffer contents need no clearing.
// ----------------------------------------------------------------------------
module iso_duration_text_parser
    import isodur_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_last_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [31:0] m_years,
    output logic [31:0] m_months,
    output logic [31:0] m_weeks,
    output logic [31:0] m_days,
    output logic [31:0] m_hours,
    output logic [31:0] m_minutes,
    output logic [31:0] m_seconds
);
    logic [7:0]      mem [MAX_CHARS];
    logic [7:0]      rd_data_reg;
    logic [LW-1:0]   len_reg, eff_reg;
    logic            long_reg, nul_reg, busy_reg, ov_reg;
    logic            acc, start, done, status;
    logic [AW-1:0]   rd_addr;
    logic [7*32-1:0] parts, out_reg;
    logic            st_reg;

    assign s_ready = !busy_reg && !ov_reg;
    assign acc     = s_valid && s_ready;
    assign m_valid = ov_reg;

    always_ff @(posedge aclk) begin
        if (acc && !long_reg && len_reg < LW'(MAX_CHARS))
            mem[len_reg[AW-1:0]] <= s_char_code;
        rd_data_reg <= mem[rd_addr];
    end

    // the closing byte raises start once stored, and go_reg registers it again to start the scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0; long_reg <= 1'b0; nul_reg <= 1'b0;
            busy_reg <= 1'b0; ov_reg <= 1'b0; start <= 1'b0;
        end else begin
            start <= acc && s_last_char;
            if (acc) begin
                if (!long_reg) begin
                    if (len_reg < LW'(MAX_CHARS)) begin
                        len_reg <= len_reg + 1'b1;
                        if (s_char_code == 8'd0 && !nul_reg) begin
                            nul_reg <= 1'b1; eff_reg <= len_reg;
                        end
                    end else begin
                        long_reg <= 1'b1;
                    end
                end
                if (s_last_char) begin
                    busy_reg <= 1'b1;
                end
            end
            if (start) begin
                if (!nul_reg) eff_reg <= len_reg;
                len_reg <= '0; nul_reg <= 1'b0;
            end
            if (done) begin
                busy_reg <= 1'b0; ov_reg <= 1'b1; long_reg <= 1'b0;
            end else if (ov_reg && m_ready) begin
                ov_reg <= 1'b0;
            end
        end
        if (done) begin
            st_reg  <= long_reg ? 1'b1 : status;
            out_reg <= long_reg ? '0 : parts;
        end
    end

    // delay start so eff_reg settles
    logic go_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) go_reg <= 1'b0;
        else          go_reg <= start;
    end

    isodur_scan u_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (go_reg),
        .eff_len (eff_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data_reg),
        .done    (done),
        .status  (status),
        .parts   (parts)
    );

    assign m_status  = st_reg;
    assign m_years   = out_reg[0*32 +: 32];
    assign m_months  = out_reg[1*32 +: 32];
    assign m_weeks   = out_reg[2*32 +: 32];
    assign m_days    = out_reg[3*32 +: 32];
    assign m_hours   = out_reg[4*32 +: 32];
    assign m_minutes = out_reg[5*32 +: 32];
    assign m_seconds = out_reg[6*32 +: 32];
endmodule

/* rtl/core/isodur_checker.sv */
// ----------------------------------------------------------------------------
// isodur_checker
// port-level checks for the duration text parser
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module isodur_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last_char,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_status,
    input logic [31:0] m_years
);
    `ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_years))
    `ASSERT_IMPL(a_no_in_while_out, aclk, aresetn, m_valid, !s_ready)
    `ASSERT_NEXT(a_last_blocks, aclk, aresetn, s_valid && s_ready && s_last_char, !s_ready)
    `ASSERT_NEXT(a_status_hold, aclk, aresetn, m_valid && !m_ready, $stable(m_status))
endmodule

bind iso_duration_text_parser isodur_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_last_char(s_last_char), .m_valid(m_valid), .m_ready(m_ready),
    .m_status(m_status), .m_years(m_years)
);

/* sim/iso_duration_text_parser_tb.sv */
// ----------------------------------------------------------------------------
// iso_duration_text_parser_tb
// self-checking bench for the duration text parser
// ----------------------------------------------------------------------------
// feeds duration texts one byte per word (well-formed with random counts,
// broken, noisy, single-byte texts) and checks every result word against
// a behavioural parser held in the bench. both sides idle at random and the
// receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module iso_duration_text_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import isodur_pkg::*;

    typedef struct packed {
        logic        status;
        logic [31:0] years;
        logic [31:0] months;
        logic [31:0] weeks;
        logic [31:0] days;
        logic [31:0] hours;
        logic [31:0] minutes;
        logic [31:0] seconds;
    } dur_t;

    typedef byte unsigned text_q_t[$];

    localparam int N_RANDOM = 950;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_char_code = '0;
    logic        s_last_char = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_status;
    logic [31:0] m_years, m_months, m_weeks, m_days, m_hours, m_minutes, m_seconds;

    dur_t  expected_durs[$];
    int    errors = 0;
    int    words_sent = 0;
    bit    feed_done = 1'b0;
    bit    hold_off = 1'b0;

    // predictor copy of the text state
    byte unsigned txt[MAX_CHARS];
    int    txt_len = 0;
    bit    txt_over = 1'b0;
    int    eff;

    iso_duration_text_parser dut (.*);

    always #10 aclk = ~aclk;

    function automatic int find_pair(int from, byte unsigned a, byte unsigned b);
        for (int i = from; i < eff; i++)
            if (txt[i] == a || txt[i] == b) return i;
        return eff;
    endfunction

    function automatic logic [31:0] atoi_wrap(int pos);
        logic [31:0] v;
        bit neg;
        v = 0;
        neg = 0;
        while (pos < eff && (txt[pos] == 8'h20 || (txt[pos] >= 9 && txt[pos] <= 13))) pos++;
        if (pos < eff && (txt[pos] == "+" || txt[pos] == "-")) begin
            neg = txt[pos] == "-";
            pos++;
        end
        while (pos < eff && txt[pos] >= "0" && txt[pos] <= "9") begin
            v = v * 10 + (txt[pos] - "0");
            pos++;
        end
        return neg ? -v : v;
    endfunction

    function automatic dur_t parse_text();
        dur_t r;
        int s, t, x;
        bit has_t, no_weeks;
        r = '0;
        r.status = 1'b1;
        if (txt_over) return r;
        eff = txt_len;
        for (int i = 0; i < txt_len; i++)
            if (txt[i] == 0) begin
                eff = i;
                break;
            end
        if (eff == 0 || (txt[0] != "P" && txt[0] != "p")) return r;
        no_weeks = 0;
        s = 0;
        t = find_pair(0, "T", "t");
        has_t = t < eff;
        x = find_pair(s, "Y", "y");
        if (x < eff) begin r.years = atoi_wrap(s + 1); s = x; no_weeks = 1; end
        x = find_pair(s, "M", "m");
        if (x < eff && (!has_t || x < t)) begin
            r.months = atoi_wrap(s + 1); s = x; no_weeks = 1;
        end
        x = find_pair(s, "D", "d");
        if (x < eff) begin r.days = atoi_wrap(s + 1); s = x; no_weeks = 1; end
        if (has_t) begin s = t; no_weeks = 1; end
        x = find_pair(s, "H", "h");
        if (x < eff && has_t) begin r.hours = atoi_wrap(s + 1); s = x; no_weeks = 1; end
        x = find_pair(s, "M", "m");
        if (x < eff && has_t && x > t) begin
            r.minutes = atoi_wrap(s + 1); s = x; no_weeks = 1;
        end
        x = find_pair(s, "S", "s");
        if (x < eff && has_t) begin r.seconds = atoi_wrap(s + 1); s = x; no_weeks = 1; end
        x = find_pair(0, "W", "w");
        if (x < eff) begin
            if (no_weeks) return r;
            r.weeks = atoi_wrap(s + 1);
            s = x;
        end
        r.status = (s + 1 < eff);
        return r;
    endfunction

    function automatic dur_t mk_dur(input bit st, input logic [31:0] y,
                                    input logic [31:0] mo, input logic [31:0] w,
                                    input logic [31:0] d, input logic [31:0] h,
                                    input logic [31:0] mi, input logic [31:0] sc);
        dur_t r;
        r.status  = st;
        r.years   = y;
        r.months  = mo;
        r.weeks   = w;
        r.days    = d;
        r.hours   = h;
        r.minutes = mi;
        r.seconds = sc;
        return r;
    endfunction

    // called once per accepted word
    task automatic note_word(input byte unsigned c, input bit last);
        if (!txt_over) begin
            if (txt_len < MAX_CHARS) txt[txt_len++] = c;
            else txt_over = 1'b1;
        end
        if (last) begin
            expected_durs.push_back(parse_text());
            txt_len = 0;
            txt_over = 1'b0;
        end
    endtask

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // valid stays up between back-to-back words and drops only for a gap
    task automatic send_text(input text_q_t t, input bit idle);
        int gap;
        foreach (t[i]) begin
            gap = idle ? gap_len() : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_valid <= 1'b1;
            s_char_code <= t[i];
            s_last_char <= (i == t.size() - 1);
            do @(posedge aclk); while (!s_ready);
            note_word(t[i], i == t.size() - 1);
            words_sent++;
            @(negedge aclk);
        end
    endtask

    function automatic text_q_t str_text(input string s);
        text_q_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    function automatic string rand_num();
        int k;
        string r;
        k = $urandom_range(0, 9);
        if (k == 0) return "";
        if (k == 1) return "4294967295";
        if (k == 2) return "99999999999";
        if (k == 3) return "-7";
        if (k == 4) return " +12";
        return $sformatf("%0d", $urandom_range(0, 5000));
    endfunction

    function automatic string rand_unit(input string u);
        return ($urandom_range(0, 1)) ? u : u.tolower();
    endfunction

    function automatic text_q_t rand_text();
        string s;
        text_q_t q;
        int k;
        k = $urandom_range(0, 19);
        if (k < 12) begin
            s = rand_unit("P");
            if ($urandom_range(0, 1)) s = {s, rand_num(), rand_unit("Y")};
            if ($urandom_range(0, 1)) s = {s, rand_num(), rand_unit("M")};
            if ($urandom_range(0, 1)) s = {s, rand_num(), rand_unit("D")};
            if ($urandom_range(0, 2) != 0) begin
                s = {s, rand_unit("T")};
                if ($urandom_range(0, 1)) s = {s, rand_num(), rand_unit("H")};
                if ($urandom_range(0, 1)) s = {s, rand_num(), rand_unit("M")};
                if ($urandom_range(0, 1)) s = {s, rand_num(), rand_unit("S")};
            end
            if ($urandom_range(0, 7) == 0) s = {s, "x"};
            q = str_text(s);
        end else if (k < 15) begin
            q = str_text({rand_unit("P"), rand_num(), rand_unit("W")});
            if ($urandom_range(0, 3) == 0) q.push_back("D");
        end else begin
            // noise, nul cuts, over-length texts
            repeat ($urandom_range(1, (k == 19) ? 70 : 12))
                q.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) q[0] = "P";
        end
        return q;
    endfunction

    initial begin
        text_q_t t;
        string   dir_s[$];
        dur_t    dir_e[$];
        bit      dir_k[$];
        dur_t    z;
        z = '0;
        dir_s = '{"P1Y2M3DT4H5M6S", "P3W", "p4294967295y", "P99999999999D", "P1W2D",
                  "P1Dx", "X1D", "PT-5M", "pt1h2m3s", "P1M", "PT1M", "P 7D", "P"};
        dir_k = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                  1'b0, 1'b0, 1'b1};
        dir_e = '{mk_dur(1'b0, 32'd1, 32'd2, 32'd0, 32'd3, 32'd4, 32'd5, 32'd6),
                  mk_dur(1'b0, 32'd0, 32'd0, 32'd3, 32'd0, 32'd0, 32'd0, 32'd0),
                  mk_dur(1'b0, 32'hffff_ffff, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0),
                  z, z, z,
                  mk_dur(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0),
                  z, z, z, z, z,
                  mk_dur(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0)};
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        foreach (dir_s[i]) begin
            send_text(str_text(dir_s[i]), 1'b0);
            if (dir_k[i]) begin
                if (expected_durs[$] != dir_e[i])
                    $error("bench: prediction for %s disagrees", dir_s[i]);
                expected_durs[$] = dir_e[i];
            end
        end
        // nul-only text and a nul cut
        send_text('{8'h00}, 1'b0);
        send_text('{"P", "2", "D", 8'h00, "z"}, 1'b0);
        // over-length, 64 bytes: P then descending byte values
        t = {};
        for (int i = 0; i < 64; i++) t.push_back(i == 0 ? "P" : 8'hff - i);
        send_text(t, 1'b0);
        z.status = 1'b1;
        if (expected_durs[$] != z) $error("bench: over-length prediction disagrees");
        t = {};
        for (int i = 0; i < 63; i++) t.push_back(i == 62 ? "D" : "0");
        t[0] = "P";
        send_text(t, 1'b0);
        for (int i = 0; i < 256; i++) send_text('{8'(i)}, 1'b0);
        while (words_sent < N_RANDOM) send_text(rand_text(), 1'b1);
        s_valid <= 1'b0;
        feed_done = 1'b1;
    end

    // receiver: random stalls and one long hold-off
    initial begin
        int waited;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (words_sent > 500 && words_sent < 520 && !hold_off) begin
                hold_off = 1'b1;
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
            end
            m_ready <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 9) == 0);
        end
    end

    always @(posedge aclk) begin
        dur_t exp_d;
        if (aresetn && m_valid && m_ready) begin
            if (expected_durs.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                exp_d = expected_durs.pop_front();
                if (m_status !== exp_d.status) begin
                    $error("status exp %0d got %0d", exp_d.status, m_status); errors++;
                end
                if (m_years !== exp_d.years) begin
                    $error("years exp %0d got %0d", exp_d.years, m_years); errors++;
                end
                if (m_months !== exp_d.months) begin
                    $error("months exp %0d got %0d", exp_d.months, m_months); errors++;
                end
                if (m_weeks !== exp_d.weeks) begin
                    $error("weeks exp %0d got %0d", exp_d.weeks, m_weeks); errors++;
                end
                if (m_days !== exp_d.days) begin
                    $error("days exp %0d got %0d", exp_d.days, m_days); errors++;
                end
                if (m_hours !== exp_d.hours) begin
                    $error("hours exp %0d got %0d", exp_d.hours, m_hours); errors++;
                end
                if (m_minutes !== exp_d.minutes) begin
                    $error("minutes exp %0d got %0d", exp_d.minutes, m_minutes); errors++;
                end
                if (m_seconds !== exp_d.seconds) begin
                    $error("seconds exp %0d got %0d", exp_d.seconds, m_seconds); errors++;
                end
            end
        end
    end

    initial begin
        wait (feed_done);
        while (expected_durs.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        if (errors == 0 && expected_durs.size() == 0) begin
            $display("** iso_duration_text_parser: PASSED **");
        end else begin
            $display("** iso_duration_text_parser: FAILED **");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("** iso_duration_text_parser: FAILED **");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/isodur_pkg.sv
rtl/core/isodur_scan.sv
rtl/core/iso_duration_text_parser.sv
rtl/core/isodur_checker.sv
sim/iso_duration_text_parser_tb.sv
